### hdl/assert_macros.svh
// Assertion macros used by the checker file of the lock manager.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("lock manager check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("lock manager check failed");

`endif

### hdl/flm_pkg.sv
// Package of the FIFO lock manager: sizes, command and status codes.
// Used by fifo_lock_manager and flm_checker; depends on nothing.
package flm_pkg;

   localparam int NUM_LOCKS  = 3;
   localparam int WAIT_DEPTH = 8;

   localparam int LOCK_IDX_W = 2;
   localparam int PID_W      = 8;
   localparam int STATUS_W   = 3;

   localparam int LOCK_W = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int PTR_W  = $clog2(WAIT_DEPTH);
   localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);

   typedef enum logic {
      CMD_ACQUIRE = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_FREED     = 3'd2,
      ST_HANDED    = 3'd3,
      ST_NOT_OWNER = 3'd4,
      ST_UNKNOWN   = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

endpackage

### hdl/fifo_lock_manager.sv
// FIFO lock manager top level: lock state, per-lock wait queues, result register.
// Depends on flm_pkg.
//
// Usage:
//   Request channel: raise start with req_cmd, req_lock_index and req_process_id;
//   the transfer happens at a rising edge where start is high and busy is low.
//   busy is high only during reset and the cycle after it, so one request can
//   be taken every cycle.
//   Response channel: each request yields exactly one response, shown for one
//   cycle with rsp_valid high. The receiver cannot stall; it must take the
//   transfer in that cycle.
//   A request passes the input register, then the lock logic into the result
//   register, which drives the response.
//   Throughput: one request per cycle while busy is low, set by the single
//   read-modify-write of one lock's flag, owner and queue pointer per cycle.
//   Configuration: csr_write_enable with csr_write_data writes the feedback
//   queue mode; write it only while no request is in flight.
//   Reset (synchronous, active high) frees every lock, empties every queue and
//   clears the mode; queue entries themselves are not cleared.
module fifo_lock_manager (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [flm_pkg::LOCK_IDX_W-1:0] req_lock_index,
   input  logic [flm_pkg::PID_W-1:0]      req_process_id,
   output logic                          rsp_valid,
   output logic [flm_pkg::STATUS_W-1:0]   rsp_status,
   output logic                          rsp_woken_valid,
   output logic [flm_pkg::PID_W-1:0]      rsp_woken_process_id,
   output logic                          rsp_woken_to_top_priority,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data
);
   import flm_pkg::*;

   // Busy and configuration
   logic busy_ff;
   logic mode_ff;

   // Input register
   logic                  req_valid_ff;
   cmd_type               req_cmd_ff;
   logic [LOCK_IDX_W-1:0] req_lock_ff;
   logic [PID_W-1:0]      req_pid_ff;

   // Lock state
   logic             lock_held_ff  [NUM_LOCKS];
   logic [PID_W-1:0] lock_owner_ff [NUM_LOCKS];
   logic [PTR_W-1:0] wait_head_ff  [NUM_LOCKS];
   logic [PTR_W-1:0] wait_tail_ff  [NUM_LOCKS];
   logic [CNT_W-1:0] wait_count_ff [NUM_LOCKS];
   logic [PID_W-1:0] wait_store_ff [NUM_LOCKS][WAIT_DEPTH];

   // Result register
   logic             rsp_valid_ff;
   status_type       rsp_status_ff;
   logic             rsp_woken_ff;
   logic [PID_W-1:0] rsp_woken_pid_ff;
   logic             rsp_top_ff;

   // Decode of the registered request
   logic             known;
   logic [LOCK_W-1:0] sel;
   logic             held;
   logic [PID_W-1:0] owner;
   logic [PTR_W-1:0] head;
   logic [PTR_W-1:0] tail;
   logic [CNT_W-1:0] count;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;
   logic [PID_W-1:0] head_pid;
   logic             do_grant;
   logic             do_enqueue;
   logic             do_free;
   logic             do_handover;
   status_type       status_in;

   assign busy                      = busy_ff;
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_status                = rsp_status_ff;
   assign rsp_woken_valid           = rsp_woken_ff;
   assign rsp_woken_process_id      = rsp_woken_pid_ff;
   assign rsp_woken_to_top_priority = rsp_top_ff;

   // Hold busy through reset and the cycle after it; take the mode write.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         mode_ff <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
      end
   end

   // Capture each request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_cmd_ff  <= cmd_type'(req_cmd);
         req_lock_ff <= req_lock_index;
         req_pid_ff  <= req_process_id;
      end
   end

   // Look up the addressed lock. For an unknown index the looked-up values
   // are never used, since every action flag is gated by known.
   assign known = 32'(req_lock_ff) < NUM_LOCKS;
   assign sel   = LOCK_W'(req_lock_ff);

   always_comb begin
      held      = lock_held_ff[sel];
      owner     = lock_owner_ff[sel];
      head      = wait_head_ff[sel];
      tail      = wait_tail_ff[sel];
      count     = wait_count_ff[sel];
      head_pid  = wait_store_ff[sel][head];
      head_next = (head == PTR_W'(WAIT_DEPTH - 1)) ? '0 : head + PTR_W'(1);
      tail_next = (tail == PTR_W'(WAIT_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
   end

   // Decide the action and the status code.
   always_comb begin
      do_grant    = 1'b0;
      do_enqueue  = 1'b0;
      do_free     = 1'b0;
      do_handover = 1'b0;
      status_in   = ST_UNKNOWN;
      if (!known) begin
         status_in = ST_UNKNOWN;
      end else if (req_cmd_ff == CMD_ACQUIRE) begin
         if (!held || owner == req_pid_ff) begin
            do_grant  = 1'b1;
            status_in = ST_GRANTED;
         end else if (count == CNT_W'(WAIT_DEPTH)) begin
            status_in = ST_FULL;
         end else begin
            do_enqueue = 1'b1;
            status_in  = ST_QUEUED;
         end
      end else begin
         if (!held || owner != req_pid_ff) begin
            status_in = ST_NOT_OWNER;
         end else if (count == '0) begin
            do_free   = 1'b1;
            status_in = ST_FREED;
         end else begin
            do_handover = 1'b1;
            status_in   = ST_HANDED;
         end
      end
   end

   // Advance the addressed lock's flag, owner and queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LOCKS; i++) begin
            lock_held_ff[i]  <= 1'b0;
            lock_owner_ff[i] <= '0;
            wait_head_ff[i]  <= '0;
            wait_tail_ff[i]  <= '0;
            wait_count_ff[i] <= '0;
         end
      end else if (req_valid_ff) begin
         if (do_grant) begin
            lock_held_ff[sel]  <= 1'b1;
            lock_owner_ff[sel] <= req_pid_ff;
         end
         if (do_enqueue) begin
            wait_tail_ff[sel]  <= tail_next;
            wait_count_ff[sel] <= count + CNT_W'(1);
         end
         if (do_free) begin
            lock_held_ff[sel]  <= 1'b0;
            lock_owner_ff[sel] <= '0;
         end
         if (do_handover) begin
            lock_owner_ff[sel] <= head_pid;
            wait_head_ff[sel]  <= head_next;
            wait_count_ff[sel] <= count - CNT_W'(1);
         end
      end
   end

   // Queue entries: written on enqueue only, no reset.
   always_ff @(posedge clock) begin
      if (req_valid_ff && do_enqueue) begin
         wait_store_ff[sel][tail] <= req_pid_ff;
      end
   end

   // Result register: strobe for one cycle per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_status_ff    <= status_in;
         rsp_woken_ff     <= do_handover;
         rsp_woken_pid_ff <= do_handover ? head_pid : '0;
         rsp_top_ff       <= do_handover & mode_ff;
      end
   end

endmodule

### hdl/flm_checker.sv
// Port-level checker for fifo_lock_manager, attached by bind below.
// Depends on flm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module flm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [flm_pkg::STATUS_W-1:0]   rsp_status,
   input logic                          rsp_woken_valid,
   input logic [flm_pkg::PID_W-1:0]      rsp_woken_process_id,
   input logic                          rsp_woken_to_top_priority
);
   import flm_pkg::*;

   logic accept;
   logic handed;
   logic woken_clear;

   assign accept      = start && !busy;
   assign handed      = rsp_status == ST_HANDED;
   assign woken_clear = (rsp_woken_process_id == '0) && !rsp_woken_to_top_priority;

   // Every request transfer answers after the input register and the result register.
   `ASSERT_NEXT(a_rsp_follows, clock, reset, accept, ##1 rsp_valid)
   // No response without a matching earlier request transfer.
   `ASSERT_IMPLIES(a_rsp_has_req, clock, reset, rsp_valid, $past(accept, 2))
   // Woken flag marks exactly the handover responses.
   `ASSERT_IMPLIES(a_woken_iff_handed, clock, reset, rsp_valid, rsp_woken_valid == handed)
   // Without a handover the woken fields read zero.
   `ASSERT_IMPLIES(a_idle_woken_zero, clock, reset, rsp_valid && !handed, woken_clear)

endmodule

bind fifo_lock_manager flm_checker u_flm_checker (.*);
